// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SLC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/slc_pkg.sv =====
`default_nettype none

package slc_pkg;

    // Field widths.
    localparam int TIME_W    = 32;
    localparam int SOC_W     = 7;
    localparam int AMP_W     = 16;
    localparam int CNT_W     = 4;
    localparam int MASK_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Default number of load stages.
    localparam int NUM_STAGES_DEF = 8;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOC_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOC_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_UP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_DOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS   = 3'd5;

    // Configuration reset values.
    localparam logic [SOC_W-1:0]        SOC_HIGH_RST     = 7'd80;
    localparam logic [SOC_W-1:0]        SOC_LOW_RST      = 7'd60;
    localparam logic signed [AMP_W-1:0] CURRENT_UP_RST   = 16'sd2;
    localparam logic signed [AMP_W-1:0] CURRENT_DOWN_RST = 16'sd0;
    localparam logic                    HEAT_ENABLE_RST  = 1'b0;
    localparam logic [TIME_W-1:0]       HOLDOFF_MS_RST   = 32'd10000;

    // One classified evaluation as it travels from the front to the back part.
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              eval;       // heating on and measurements valid
        logic              shed;       // heating off: shed every stage
        logic              soc_below;  // charge below the low threshold
        logic              soc_above;  // charge at or above the high threshold
        logic              amps_up;    // current at or above the upper limit
        logic              amps_down;  // current at or below the lower limit
    } t_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Highest stage count, saturated to what the count field can hold.
    function automatic logic [CNT_W-1:0] f_max_stages(input int n);
        logic [CNT_W-1:0] m;
        if (n > (2 ** CNT_W - 1)) begin
            m = CNT_W'(2 ** CNT_W - 1);
        end else begin
            m = CNT_W'(n);
        end
        return m;
    endfunction

    // Active-low relay drive: bit i is low while i is below the stage count.
    function automatic logic [MASK_W-1:0] f_relay_mask(input logic [CNT_W-1:0] cnt);
        logic [MASK_W-1:0] mask;
        for (int i = 0; i < MASK_W; i++) begin
            mask[i] = (i >= int'(cnt));
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== design/slc_if.sv =====
`default_nettype none

// Evaluation input channel.
interface slc_in_if;
    logic                                valid;
    logic                                ready;
    logic [slc_pkg::TIME_W-1:0]          now_ms;
    logic [slc_pkg::SOC_W-1:0]           charge_pct;
    logic signed [slc_pkg::AMP_W-1:0]    batt_amps;
    logic                                meter_ok;

    modport source (output valid, now_ms, charge_pct, batt_amps, meter_ok, input ready);
    modport sink   (input valid, now_ms, charge_pct, batt_amps, meter_ok, output ready);
endinterface

// Result output channel.
interface slc_out_if;
    logic                          valid;
    logic                          ready;
    logic [slc_pkg::CNT_W-1:0]     stage_count;
    logic [slc_pkg::MASK_W-1:0]    relay_mask;
    logic                          mode_on;

    modport source (output valid, stage_count, relay_mask, mode_on, input ready);
    modport sink   (input valid, stage_count, relay_mask, mode_on, output ready);
endinterface

// Configuration write channel.
interface slc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [slc_pkg::CFG_IDX_W-1:0]     index;
    logic [slc_pkg::CFG_DAT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/slc_front.sv =====
`default_nettype none

module slc_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    slc_in_if.sink                       i_in,
    slc_cfg_if.sink                      i_cfg,
    input  wire slc_pkg::t_q_stat        i_q_stat,
    output logic                         o_push,
    output slc_pkg::t_item               o_item,
    output logic [slc_pkg::TIME_W-1:0]   o_holdoff_ms
);

    logic [slc_pkg::SOC_W-1:0]        r_soc_high;
    logic [slc_pkg::SOC_W-1:0]        r_soc_low;
    logic signed [slc_pkg::AMP_W-1:0] r_current_up;
    logic signed [slc_pkg::AMP_W-1:0] r_current_down;
    logic                             r_heat_enable;
    logic [slc_pkg::TIME_W-1:0]       r_holdoff_ms;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soc_high     <= slc_pkg::SOC_HIGH_RST;
            r_soc_low      <= slc_pkg::SOC_LOW_RST;
            r_current_up   <= slc_pkg::CURRENT_UP_RST;
            r_current_down <= slc_pkg::CURRENT_DOWN_RST;
            r_heat_enable  <= slc_pkg::HEAT_ENABLE_RST;
            r_holdoff_ms   <= slc_pkg::HOLDOFF_MS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                slc_pkg::REG_SOC_HIGH:     r_soc_high     <= i_cfg.data[slc_pkg::SOC_W-1:0];
                slc_pkg::REG_SOC_LOW:      r_soc_low      <= i_cfg.data[slc_pkg::SOC_W-1:0];
                slc_pkg::REG_CURRENT_UP:   r_current_up   <= i_cfg.data[slc_pkg::AMP_W-1:0];
                slc_pkg::REG_CURRENT_DOWN: r_current_down <= i_cfg.data[slc_pkg::AMP_W-1:0];
                slc_pkg::REG_HEAT_ENABLE:  r_heat_enable  <= i_cfg.data[0];
                slc_pkg::REG_HOLDOFF_MS:   r_holdoff_ms   <= i_cfg.data[slc_pkg::TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // An evaluation is taken whenever the queue has room.
    assign i_in.ready   = !i_q_stat.full;
    assign o_push       = i_in.valid && !i_q_stat.full;
    assign o_holdoff_ms = r_holdoff_ms;

    // Classify the evaluation against the thresholds; none of this needs state.
    always_comb begin
        o_item.now_ms    = i_in.now_ms;
        o_item.eval      = r_heat_enable && i_in.meter_ok;
        o_item.shed      = !r_heat_enable;
        o_item.soc_below = i_in.charge_pct < r_soc_low;
        o_item.soc_above = i_in.charge_pct >= r_soc_high;
        o_item.amps_up   = i_in.batt_amps >= r_current_up;
        o_item.amps_down = i_in.batt_amps <= r_current_down;
    end

endmodule

`default_nettype wire

// ===== design/slc_queue.sv =====
`default_nettype none

module slc_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire slc_pkg::t_item     i_item,
    input  wire                     i_pop,
    output slc_pkg::t_q_stat        o_stat,
    output slc_pkg::t_item          o_head
);

    localparam int                     DEPTH   = slc_pkg::QUEUE_DEPTH;
    localparam logic [slc_pkg::QPTR_W-1:0] PTR_LAST = slc_pkg::QPTR_W'(DEPTH - 1);
    localparam logic [slc_pkg::QCNT_W-1:0] CNT_FULL = slc_pkg::QCNT_W'(DEPTH);

    slc_pkg::t_item                r_mem [DEPTH];
    logic [slc_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [slc_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [slc_pkg::QCNT_W-1:0]    r_count;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/slc_back.sv =====
`default_nettype none

module slc_back #(
    parameter int NUM_STAGES = slc_pkg::NUM_STAGES_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire slc_pkg::t_q_stat        i_q_stat,
    input  wire slc_pkg::t_item          i_head,
    input  wire [slc_pkg::TIME_W-1:0]    i_holdoff_ms,
    output logic                         o_pop,
    slc_out_if.source                    o_out
);

    localparam logic [slc_pkg::CNT_W-1:0] MAX_STAGES = slc_pkg::f_max_stages(NUM_STAGES);

    logic [slc_pkg::CNT_W-1:0]   r_stages;
    logic                        r_mode;
    logic [slc_pkg::TIME_W-1:0]  r_last;
    logic                        r_out_valid;
    logic [slc_pkg::MASK_W-1:0]  r_relay_mask;

    logic [slc_pkg::CNT_W-1:0]   n_stages;
    logic                        n_mode;
    logic [slc_pkg::TIME_W-1:0]  n_last;
    logic [slc_pkg::TIME_W-1:0]  elapsed;
    logic                        fire;

    // Work on the queue head when the result slot is empty or being drained.
    assign fire  = !i_q_stat.empty && (!r_out_valid || o_out.ready);
    assign o_pop = fire;

    // Elapsed time since the last switch decision, wrapping modulo 2^32.
    assign elapsed = i_head.now_ms - r_last;

    // State update for one evaluation.
    always_comb begin
        n_stages = r_stages;
        n_mode   = r_mode;
        n_last   = r_last;
        if (i_head.eval) begin
            if (i_head.soc_below) begin
                n_mode   = 1'b0;
                n_stages = '0;
            end
            if (i_head.soc_above) begin
                n_mode = 1'b1;
            end
            if (elapsed > i_holdoff_ms) begin
                if (n_mode && i_head.amps_up) begin
                    if (n_stages < MAX_STAGES) begin
                        n_stages = n_stages + 1'b1;
                    end
                    n_last = i_head.now_ms;
                end
                if (n_mode && i_head.amps_down) begin
                    if (n_stages != '0) begin
                        n_stages = n_stages - 1'b1;
                    end
                    n_last = i_head.now_ms;
                end
            end
        end else if (i_head.shed) begin
            n_stages = '0;
        end
    end

    // Controller state doubles as the result register, since it only moves
    // when a new result is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages     <= '0;
            r_mode       <= 1'b0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
            r_relay_mask <= slc_pkg::f_relay_mask('0);
        end else begin
            if (fire) begin
                r_stages     <= n_stages;
                r_mode       <= n_mode;
                r_last       <= n_last;
                r_relay_mask <= slc_pkg::f_relay_mask(n_stages);
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.stage_count = r_stages;
    assign o_out.relay_mask  = r_relay_mask;
    assign o_out.mode_on     = r_mode;

endmodule

`default_nettype wire

// ===== design/staged_load_controller.sv =====
// Path: an accepted input is written into the two-entry queue; the back part
// then loads it from the queue head into the result register when the output is free.
// Throughput: one evaluation per cycle while the output is not stalled, set by
// the state update in the back part (one 32-bit subtract and compare plus the count step).
// Reset: synchronous, active low; loads register defaults, clears stage
// count, mode and last switch time, and empties the queue and output.
`default_nettype none

module staged_load_controller #(
    parameter int NUM_STAGES = slc_pkg::NUM_STAGES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    slc_in_if.sink     i_in,
    slc_cfg_if.sink    i_cfg,
    slc_out_if.source  o_out
);

    slc_pkg::t_q_stat              q_stat;
    slc_pkg::t_item                push_item;
    slc_pkg::t_item                head_item;
    logic                          push;
    logic                          pop;
    logic [slc_pkg::TIME_W-1:0]    holdoff_ms;

    // Front part: configuration and classification.
    slc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_item       (push_item),
        .o_holdoff_ms (holdoff_ms)
    );

    // Queue between the two parts.
    slc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_item)
    );

    // Back part: staging state and result register.
    slc_back #(
        .NUM_STAGES (NUM_STAGES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_head       (head_item),
        .i_holdoff_ms (holdoff_ms),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ===== design/slc_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module slc_chk (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [slc_pkg::CNT_W-1:0]     i_stage_count,
    input wire [slc_pkg::MASK_W-1:0]    i_relay_mask,
    input wire                          i_mode_on
);

    // A stalled result keeps its valid and its payload.
    `SLC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_stage_count) && $stable(i_relay_mask) && $stable(i_mode_on), "stalled result changed")

    // The relay drive agrees with the stage count whenever a result is valid.
    `SLC_ASSERT(a_mask_match, i_clk, i_rst_n, i_out_valid |-> i_relay_mask == ~slc_pkg::MASK_W'((16'd1 << i_stage_count) - 16'd1), "relay mask disagrees with stage count")

    // Stages can only be on while the mode allows staging.
    `SLC_ASSERT(a_stage_mode, i_clk, i_rst_n, i_out_valid && i_stage_count != '0 |-> i_mode_on, "stages on with mode cleared")

    // Reset leaves no result pending.
    `SLC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind staged_load_controller slc_chk u_slc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_stage_count (o_out.stage_count),
    .i_relay_mask  (o_out.relay_mask),
    .i_mode_on     (o_out.mode_on)
);

`default_nettype wire
